/* design/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// CRC keyed topic table package
// Shared widths, codes, beat types and control groups for the topic table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int KEY_W           = 16;
   localparam int SLOT_W          = 5;
   localparam int KIND_W          = 3;
   localparam int BYTE_W          = 8;

   localparam logic [KEY_W-1:0] CRC_POLY = 16'h8005;
   localparam logic [KEY_W-1:0] CRC_TOP  = 16'h8000;

   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] topic_byte;
      logic              last;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_FINISH,
      ST_SCAN,
      ST_CHECK
   } state_type;

   typedef enum logic [1:0] {
      MODE_ADD,
      MODE_LOOKUP,
      MODE_FIRST,
      MODE_NEXT
   } mode_type;

   typedef struct packed {
      logic start;
      logic clear;
   } crc_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } tbl_ctl_type;

endpackage

`default_nettype wire

/* design/crc_keyed_topic_table_core.sv */
// ----------------------------------------------------------------------------
// CRC keyed topic table
// Topic bytes feed a bit-serial CRC-16/ARC; the last byte adds or looks up
// the key in the slot table, and walk commands visit valid slots in order.
// ----------------------------------------------------------------------------
// Each add or lookup byte keeps busy high while the CRC unit steps through the byte's bits,
// so a new byte is taken only once busy drops. On a last byte, the FINISH state and then
// a slot scan follow: an add tests one slot per cycle, a lookup or a walk passes each
// valid slot through SCAN (key memory read) and then CHECK (compare). Clear, and
// walk-next with no walk, leave busy low. The receiver cannot stall. Reset empties
// the valid map at once; no clearing pass is needed.
`default_nettype none

module crc_keyed_topic_table_core #(
   parameter int TABLE_DEPTH = ctp_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ctp_pkg::req_type req_data,
   output logic             rsp_valid,
   output ctp_pkg::rsp_type rsp_data
);
   import ctp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   req_type           req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              walk_active_ff, walk_active_in;
   logic [IDX_W-1:0]  walk_pos_ff, walk_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   crc_ctl_type       crc_ctl;
   logic              crc_done;
   logic [KEY_W-1:0]  crc_key;
   tbl_ctl_type       tbl_ctl;
   logic              valid_at;
   logic [KEY_W-1:0]  rd_key;

   logic              accept;
   logic              at_end;
   logic              walk_can_step;
   logic              key_match;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic [SLOT_W-1:0] slot_now;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign at_end        = (idx_ff == LAST_IDX);
   assign walk_can_step = walk_active_ff && (walk_pos_ff != LAST_IDX);
   assign key_match     = (rd_key == key_ff);
   assign slot_ext      = {{SLOT_W{1'b0}}, idx_ff};
   assign slot_now      = slot_ext[SLOT_W-1:0];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   ctp_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (req_data.topic_byte),
      .done  (crc_done),
      .key   (crc_key)
   );

   ctp_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .addr     (idx_ff),
      .wr_key   (key_ff),
      .valid_at (valid_at),
      .rd_key   (rd_key)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_ADD, KIND_LOOKUP: state_in = ST_CRC;
                  KIND_FIRST:            state_in = ST_SCAN;
                  KIND_NEXT:             state_in = walk_can_step ? ST_SCAN : ST_IDLE;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_CRC: begin
            if (crc_done) begin
               state_in = req_ff.last ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: state_in = ST_SCAN;
         ST_SCAN: begin
            if (mode_ff == MODE_ADD) begin
               if (!valid_at || at_end) begin
                  state_in = ST_IDLE;
               end
            end else if (valid_at) begin
               state_in = ST_CHECK;
            end else if (at_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (mode_ff != MODE_LOOKUP || key_match || at_end) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs.
   always_comb begin
      mode_in        = mode_ff;
      req_in         = req_ff;
      idx_in         = idx_ff;
      key_in         = key_ff;
      walk_active_in = walk_active_ff;
      walk_pos_in    = walk_pos_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      crc_ctl        = '0;
      tbl_ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               unique case (req_data.kind)
                  KIND_ADD, KIND_LOOKUP: crc_ctl.start = 1'b1;
                  KIND_CLEAR:            tbl_ctl.clear = 1'b1;
                  KIND_FIRST: begin
                     mode_in = MODE_FIRST;
                     idx_in  = '0;
                  end
                  KIND_NEXT: begin
                     if (walk_can_step) begin
                        mode_in = MODE_NEXT;
                        idx_in  = walk_pos_ff + 1'b1;
                     end else begin
                        // Either no walk is open or the last slot was visited.
                        rsp_valid_in   = 1'b1;
                        rsp_in         = '0;
                        walk_active_in = 1'b0;
                        walk_pos_in    = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CRC: ;
         ST_FINISH: begin
            key_in        = crc_key;
            crc_ctl.clear = 1'b1;
            idx_in        = '0;
            mode_in       = (req_ff.kind == KIND_ADD) ? MODE_ADD : MODE_LOOKUP;
         end
         ST_SCAN: begin
            if (mode_ff == MODE_ADD) begin
               if (!valid_at) begin
                  tbl_ctl.wr_en = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '{hit: 1'b1, slot: slot_now, key: key_ff};
               end else if (at_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{hit: 1'b0, slot: '0, key: key_ff};
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (!valid_at) begin
               if (at_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{hit: 1'b0, slot: '0,
                                   key: (mode_ff == MODE_LOOKUP) ? key_ff : '0};
                  if (mode_ff == MODE_NEXT) begin
                     walk_active_in = 1'b0;
                     walk_pos_in    = '0;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (mode_ff == MODE_LOOKUP) begin
               if (key_match) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{hit: 1'b1, slot: slot_now, key: key_ff};
               end else if (at_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{hit: 1'b0, slot: '0, key: key_ff};
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '{hit: 1'b1, slot: slot_now, key: rd_key};
               walk_active_in = 1'b1;
               walk_pos_in    = idx_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         walk_active_ff <= 1'b0;
         walk_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_active_ff <= walk_active_in;
         walk_pos_ff    <= walk_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

/* design/ctp_crc.sv */
// ----------------------------------------------------------------------------
// CRC-16 bit-serial unit
// Shifts one topic byte into the running CRC-16/ARC register, one bit per
// cycle, LSB first. The key is the running register bit-reversed.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_crc (
   input  logic                         clock,
   input  logic                         reset,
   input  ctp_pkg::crc_ctl_type         ctl,
   input  logic [ctp_pkg::BYTE_W-1:0]   data,
   output logic                         done,
   output logic [ctp_pkg::KEY_W-1:0]    key
);
   import ctp_pkg::*;

   localparam int CNT_W = $clog2(BYTE_W);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BYTE_W - 1);

   logic [KEY_W-1:0]  crc_ff;
   logic [KEY_W-1:0]  crc_in;
   logic [BYTE_W-1:0] shift_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              run_ff;
   logic              feedback;

   assign feedback = (|(crc_ff & CRC_TOP)) ^ shift_ff[0];
   assign crc_in   = {crc_ff[KEY_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
   assign done     = run_ff && (count_ff == LAST_BIT);

   always_comb begin
      for (int i = 0; i < KEY_W; i++) begin
         key[i] = crc_ff[KEY_W-1-i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
         crc_ff   <= '0;
      end else begin
         if (ctl.start) begin
            run_ff   <= 1'b1;
            count_ff <= '0;
         end else if (run_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_BIT) begin
               run_ff <= 1'b0;
            end
         end
         if (ctl.clear) begin
            crc_ff <= '0;
         end else if (run_ff) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         shift_ff <= data;
      end else if (run_ff) begin
         shift_ff <= {1'b0, shift_ff[BYTE_W-1:1]};
      end
   end

endmodule

`default_nettype wire

/* design/ctp_table.sv */
// ----------------------------------------------------------------------------
// Topic key table
// Key memory with one registered read port and one write port, plus the
// per-slot valid map held in flip-flops and cleared at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_table #(
   parameter int TABLE_DEPTH = ctp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctp_pkg::tbl_ctl_type           ctl,
   input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
   input  logic [ctp_pkg::KEY_W-1:0]      wr_key,
   output logic                           valid_at,
   output logic [ctp_pkg::KEY_W-1:0]      rd_key
);
   import ctp_pkg::*;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [KEY_W-1:0]       key_mem_ff [TABLE_DEPTH];
   logic [KEY_W-1:0]       rd_key_ff;

   assign valid_at = valid_ff[addr];
   assign rd_key   = rd_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem_ff[addr] <= wr_key;
      end
      rd_key_ff <= key_mem_ff[addr];
   end

endmodule

`default_nettype wire

/* design/ctp_checker.sv */
// ----------------------------------------------------------------------------
// Topic table port checker
// Watches the command and result ports of the topic table over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire ctp_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire ctp_pkg::rsp_type rsp_data
);
   import ctp_pkg::*;

   // A miss always reports slot zero.
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.slot == '0)
      else $error("miss beat carries a nonzero slot");

   // A result beat closes the command, so the block is ready again.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while the block is still busy");

   // A result follows either an accepted command or a busy period.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || ($past(start) && !$past(busy)))
      else $error("result beat without a command");

   // Clearing the table gives no result and leaves the block idle.
   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_CLEAR |=> !rsp_valid && !busy)
      else $error("clear produced a result or stayed busy");

   // The block comes out of reset idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind crc_keyed_topic_table_core ctp_checker u_ctp_checker (.*);

`default_nettype wire
